[hw/rtl/page_mapped_flash_translation_top_macros.svh]
// Assertion macros for the page-mapped flash translation block.
// Included by the top level; no other dependencies.
`ifndef PAGE_MAPPED_FLASH_TRANSLATION_TOP_MACROS_SVH
`define PAGE_MAPPED_FLASH_TRANSLATION_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define PMFT_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pmft assertion failed");
`define PMFT_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pmft assertion failed");
`else
`define PMFT_ASSERT_IMP(name, clk, rst, ante, cons)
`define PMFT_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

[hw/rtl/pmft_pkg.sv]
// Shared types and constants for the page-mapped flash translation block.
// Used by the controller, the datapath and the top level.
package pmft_pkg;

  // Default geometry.
  localparam int PAGES_IN_BLOCK_DEF = 16;
  localparam int BLOCK_COUNT_DEF    = 64;
  localparam int LOGICAL_COUNT_DEF  = 512;

  // At most this many migration notices are reported per request.
  localparam logic [3:0] NOTICE_CAP = 4'd15;

  // Page states.
  localparam logic [1:0] PG_FREE    = 2'd0;
  localparam logic [1:0] PG_VALID   = 2'd1;
  localparam logic [1:0] PG_INVALID = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_UNMAPPED = 2'd2;
  localparam logic [1:0] ST_NO_SPACE = 2'd3;

  // Result kinds and request operations.
  localparam logic KIND_FINAL  = 1'b0;
  localparam logic KIND_NOTICE = 1'b1;
  localparam logic OP_WRITE    = 1'b0;
  localparam logic OP_READ     = 1'b1;

  // Output field widths.
  localparam int PHYS_W  = 10;
  localparam int MOVED_W = 9;

  // Datapath commands issued by the controller.
  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_CLEAR,
    CMD_LATCH,
    CMD_MAP_RD,
    CMD_HOST_WR,
    CMD_INV_A,
    CMD_INV_B,
    CMD_FREE_INIT,
    CMD_FREE_RD,
    CMD_FREE_CHK,
    CMD_PROG_HOST,
    CMD_PROG_MOVE,
    CMD_GC_INIT,
    CMD_VS_RD,
    CMD_VS_CHK,
    CMD_PG_INIT,
    CMD_MG_RD,
    CMD_MG_CHK,
    CMD_PG_NEXT,
    CMD_ER_STEP,
    CMD_ER_DONE,
    CMD_EMIT_RANGE,
    CMD_EMIT_READ,
    CMD_EMIT_WRITE,
    CMD_EMIT_FAIL,
    CMD_EMIT_NOTICE
  } dp_cmd_t;

  // Datapath status seen by the controller.
  typedef struct packed {
    logic clr_end;
    logic range_bad;
    logic op_read;
    logic map_hit;
    logic inv_ok;
    logic free_hit;
    logic scan_end;
    logic vs_end;
    logic found;
    logic mg_move;
    logic pg_end;
    logic notice_ok;
    logic out_busy;
  } dp_stat_t;

endpackage

[hw/rtl/pmft_datapath.sv]
// Datapath of the flash translation block: tables, scan registers, counters
// and the result word register. Depends on pmft_pkg.
module pmft_datapath #(
  parameter int PAGES_IN_BLOCK = pmft_pkg::PAGES_IN_BLOCK_DEF,
  parameter int BLOCK_COUNT    = pmft_pkg::BLOCK_COUNT_DEF,
  parameter int LOGICAL_COUNT  = pmft_pkg::LOGICAL_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  pmft_pkg::dp_cmd_t  cmd,
  input  logic [15:0]        s_tdata,
  input  logic               s_tuser,
  input  logic               m_tready,
  output logic               m_tvalid,
  output logic [127:0]       m_tdata,
  output logic               m_tuser,
  output logic               m_tlast,
  output pmft_pkg::dp_stat_t stat
);

  localparam int BW = $clog2(BLOCK_COUNT);
  localparam int OW = $clog2(PAGES_IN_BLOCK);
  localparam int AW = BW + OW;
  localparam int LW = (LOGICAL_COUNT > 1) ? $clog2(LOGICAL_COUNT) : 1;
  localparam int SW = $clog2(PAGES_IN_BLOCK + 1);
  localparam int CW = $clog2(BLOCK_COUNT * PAGES_IN_BLOCK);
  localparam int ASPAN = 2 ** AW;
  localparam int CLR_LEN = (ASPAN > LOGICAL_COUNT) ? ASPAN : LOGICAL_COUNT;
  localparam int KW = $clog2(CLR_LEN);
  localparam int PW = pmft_pkg::PHYS_W;
  localparam int MW = pmft_pkg::MOVED_W;

  // Memories; page addresses are {block, offset}.
  logic [1:0]    status_mem [ASPAN];
  logic [LW-1:0] owner_mem  [ASPAN];
  logic [AW:0]   map_mem    [LOGICAL_COUNT];
  logic [SW-1:0] stale_mem  [BLOCK_COUNT];

  logic [1:0]    stat_q;
  logic [LW-1:0] own_q;
  logic [AW:0]   map_q;
  logic [SW-1:0] stale_q;

  // Request and scan registers.
  logic          range_bad;
  logic          op_r;
  logic [LW-1:0] lba_r;
  logic [LW-1:0] mv_lba;
  logic [AW-1:0] inv_pg;
  logic [AW-1:0] dst;
  logic [AW-1:0] scan_ptr;
  logic [CW-1:0] scan_cnt;
  logic [BW-1:0] blk_idx;
  logic [BW-1:0] victim;
  logic [SW-1:0] best;
  logic          found;
  logic [OW-1:0] pg_off;
  logic [3:0]    notices;

  // Control registers.
  logic [AW-1:0] cursor;
  logic [31:0]   host_writes;
  logic [31:0]   flash_writes;
  logic [31:0]   collections;
  logic [KW-1:0] clr_idx;

  // Result word register.
  logic          out_valid;
  logic          out_kind;
  logic [1:0]    out_status;
  logic [PW-1:0] out_phys;
  logic [MW-1:0] out_moved;
  logic [PW-1:0] out_src;
  logic [31:0]   out_host;
  logic [31:0]   out_flash;
  logic [31:0]   out_coll;

  logic [AW-1:0] src_addr;
  logic          emit;
  logic          stale_gt;

  // Memory port controls.
  logic          st_re, st_we, own_re, own_we, map_re, map_we, sc_re, sc_we;
  logic [AW-1:0] st_ra, st_wa;
  logic [1:0]    st_wd;
  logic [LW-1:0] map_wa;
  logic [AW:0]   map_wd;
  logic [BW-1:0] sc_ra, sc_wa;
  logic [SW-1:0] sc_wd;

  // Next page in rotating order, wrapping at the last block.
  function automatic logic [AW-1:0] next_page(input logic [AW-1:0] a);
    logic [BW-1:0] b;
    logic [OW-1:0] o;
    b = a[AW-1:OW];
    o = a[OW-1:0];
    if (o == OW'(PAGES_IN_BLOCK - 1)) begin
      o = '0;
      b = (b == BW'(BLOCK_COUNT - 1)) ? '0 : b + 1'b1;
    end else begin
      o = o + 1'b1;
    end
    return {b, o};
  endfunction

  // Linear page number, masked to the result field width.
  function automatic logic [PW-1:0] lin_page(input logic [AW-1:0] a);
    logic [AW-1:0]    l;
    logic [AW+PW-1:0] t;
    l = AW'(a[AW-1:OW]) * AW'(PAGES_IN_BLOCK) + AW'(a[OW-1:0]);
    t = {{PW{1'b0}}, l};
    return t[PW-1:0];
  endfunction

  function automatic logic [MW-1:0] moved_field(input logic [LW-1:0] a);
    logic [LW+MW-1:0] t;
    t = {{MW{1'b0}}, a};
    return t[MW-1:0];
  endfunction

  assign src_addr = {victim, pg_off};
  assign stale_gt = stale_q > best;
  assign emit = (cmd == pmft_pkg::CMD_EMIT_RANGE) || (cmd == pmft_pkg::CMD_EMIT_READ) ||
                (cmd == pmft_pkg::CMD_EMIT_WRITE) || (cmd == pmft_pkg::CMD_EMIT_FAIL) ||
                (cmd == pmft_pkg::CMD_EMIT_NOTICE);

  // Port selection for the four tables.
  always_comb begin
    st_re  = 1'b0; st_we = 1'b0; st_ra = scan_ptr; st_wa = dst; st_wd = pmft_pkg::PG_FREE;
    own_re = 1'b0; own_we = 1'b0;
    map_re = 1'b0; map_we = 1'b0; map_wa = lba_r; map_wd = {1'b1, dst};
    sc_re  = 1'b0; sc_we = 1'b0; sc_ra = blk_idx; sc_wa = inv_pg[AW-1:OW];
    sc_wd  = stale_q + 1'b1;
    case (cmd)
      pmft_pkg::CMD_CLEAR: begin
        st_we  = {1'b0, clr_idx} < (KW+1)'(ASPAN);
        st_wa  = AW'(clr_idx);
        map_we = {1'b0, clr_idx} < (KW+1)'(LOGICAL_COUNT);
        map_wa = LW'(clr_idx);
        map_wd = '0;
        sc_we  = {1'b0, clr_idx} < (KW+1)'(BLOCK_COUNT);
        sc_wa  = BW'(clr_idx);
        sc_wd  = '0;
      end
      pmft_pkg::CMD_MAP_RD: map_re = 1'b1;
      pmft_pkg::CMD_HOST_WR: begin
        st_re  = 1'b1;
        own_re = 1'b1;
        st_ra  = map_q[AW-1:0];
      end
      pmft_pkg::CMD_INV_A: begin
        st_we = 1'b1;
        st_wa = inv_pg;
        st_wd = pmft_pkg::PG_INVALID;
        sc_re = 1'b1;
        sc_ra = inv_pg[AW-1:OW];
      end
      pmft_pkg::CMD_INV_B: sc_we = 1'b1;
      pmft_pkg::CMD_FREE_RD: st_re = 1'b1;
      pmft_pkg::CMD_PROG_HOST: begin
        st_we  = 1'b1;
        st_wd  = pmft_pkg::PG_VALID;
        own_we = 1'b1;
        map_we = 1'b1;
      end
      pmft_pkg::CMD_PROG_MOVE: begin
        st_we  = 1'b1;
        st_wd  = pmft_pkg::PG_VALID;
        own_we = 1'b1;
        map_we = 1'b1;
        map_wa = mv_lba;
      end
      pmft_pkg::CMD_VS_RD: sc_re = 1'b1;
      pmft_pkg::CMD_MG_RD: begin
        st_re  = 1'b1;
        own_re = 1'b1;
        st_ra  = src_addr;
      end
      pmft_pkg::CMD_ER_STEP: begin
        st_we = 1'b1;
        st_wa = src_addr;
      end
      pmft_pkg::CMD_ER_DONE: begin
        sc_we = 1'b1;
        sc_wa = victim;
        sc_wd = '0;
      end
      default: ;
    endcase
  end

  // Table storage with registered reads.
  always_ff @(posedge clk) begin
    if (st_we) status_mem[st_wa] <= st_wd;
    if (st_re) stat_q <= status_mem[st_ra];
  end

  always_ff @(posedge clk) begin
    if (own_we) owner_mem[dst] <= map_wa;
    if (own_re) own_q <= owner_mem[st_ra];
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    if (map_re) map_q <= map_mem[lba_r];
  end

  always_ff @(posedge clk) begin
    if (sc_we) stale_mem[sc_wa] <= sc_wd;
    if (sc_re) stale_q <= stale_mem[sc_ra];
  end

  // Counters, cursor, clearing index and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor       <= '0;
      host_writes  <= '0;
      flash_writes <= '0;
      collections  <= '0;
      clr_idx      <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd == pmft_pkg::CMD_CLEAR) clr_idx <= clr_idx + 1'b1;
      if (cmd == pmft_pkg::CMD_HOST_WR) host_writes <= host_writes + 32'd1;
      if (cmd == pmft_pkg::CMD_PROG_HOST || cmd == pmft_pkg::CMD_PROG_MOVE) begin
        flash_writes <= flash_writes + 32'd1;
      end
      if (cmd == pmft_pkg::CMD_GC_INIT) collections <= collections + 32'd1;
      if (cmd == pmft_pkg::CMD_FREE_CHK && stat_q == pmft_pkg::PG_FREE) begin
        cursor <= next_page(scan_ptr);
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk) begin
    case (cmd)
      pmft_pkg::CMD_LATCH: begin
        op_r      <= s_tuser;
        lba_r     <= s_tdata[LW-1:0];
        range_bad <= {1'b0, s_tdata} >= 17'(LOGICAL_COUNT);
        notices   <= '0;
      end
      pmft_pkg::CMD_HOST_WR: inv_pg <= map_q[AW-1:0];
      pmft_pkg::CMD_FREE_INIT: begin
        scan_ptr <= cursor;
        scan_cnt <= '0;
      end
      pmft_pkg::CMD_FREE_CHK: begin
        if (stat_q == pmft_pkg::PG_FREE) begin
          dst <= scan_ptr;
        end else begin
          scan_ptr <= next_page(scan_ptr);
          scan_cnt <= scan_cnt + 1'b1;
        end
      end
      pmft_pkg::CMD_GC_INIT: begin
        blk_idx <= '0;
        best    <= '0;
        found   <= 1'b0;
      end
      pmft_pkg::CMD_VS_CHK: begin
        if (stale_gt) begin
          best   <= stale_q;
          victim <= blk_idx;
          found  <= 1'b1;
        end
        blk_idx <= blk_idx + 1'b1;
      end
      pmft_pkg::CMD_PG_INIT: pg_off <= '0;
      pmft_pkg::CMD_MG_CHK: begin
        mv_lba <= own_q;
        inv_pg <= src_addr;
      end
      pmft_pkg::CMD_PG_NEXT, pmft_pkg::CMD_ER_STEP: pg_off <= pg_off + 1'b1;
      pmft_pkg::CMD_EMIT_NOTICE: notices <= notices + 1'b1;
      default: ;
    endcase
  end

  // Result word load.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind   <= pmft_pkg::KIND_FINAL;
      out_status <= pmft_pkg::ST_OK;
      out_phys   <= '0;
      out_moved  <= '0;
      out_src    <= '0;
      out_host   <= host_writes;
      out_flash  <= flash_writes;
      out_coll   <= collections;
      case (cmd)
        pmft_pkg::CMD_EMIT_RANGE: out_status <= pmft_pkg::ST_RANGE;
        pmft_pkg::CMD_EMIT_READ: begin
          if (map_q[AW]) begin
            out_phys <= lin_page(map_q[AW-1:0]);
          end else begin
            out_status <= pmft_pkg::ST_UNMAPPED;
          end
        end
        pmft_pkg::CMD_EMIT_WRITE: out_phys <= lin_page(dst);
        pmft_pkg::CMD_EMIT_FAIL: out_status <= pmft_pkg::ST_NO_SPACE;
        pmft_pkg::CMD_EMIT_NOTICE: begin
          out_kind  <= pmft_pkg::KIND_NOTICE;
          out_phys  <= lin_page(dst);
          out_moved <= moved_field(mv_lba);
          out_src   <= lin_page(src_addr);
        end
        default: ;
      endcase
    end
  end

  // Status toward the controller.
  always_comb begin
    stat.clr_end   = clr_idx == KW'(CLR_LEN - 1);
    stat.range_bad = range_bad;
    stat.op_read   = op_r == pmft_pkg::OP_READ;
    stat.map_hit   = map_q[AW];
    stat.inv_ok    = (stat_q == pmft_pkg::PG_VALID) && (own_q == lba_r);
    stat.free_hit  = stat_q == pmft_pkg::PG_FREE;
    stat.scan_end  = scan_cnt == CW'(BLOCK_COUNT * PAGES_IN_BLOCK - 1);
    stat.vs_end    = blk_idx == BW'(BLOCK_COUNT - 1);
    stat.found     = found || stale_gt;
    stat.mg_move   = (stat_q == pmft_pkg::PG_VALID) &&
                     ({1'b0, own_q} < (LW+1)'(LOGICAL_COUNT));
    stat.pg_end    = pg_off == OW'(PAGES_IN_BLOCK - 1);
    stat.notice_ok = notices != pmft_pkg::NOTICE_CAP;
    stat.out_busy  = out_valid && !m_tready;
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_kind == pmft_pkg::KIND_FINAL;
  assign m_tdata  = {1'b0, out_coll, out_flash, out_host, out_src, out_moved,
                     out_phys, out_status};

endmodule

[hw/rtl/pmft_controller.sv]
// Controller state machine of the flash translation block: sequences the
// table walks and issues datapath commands. Depends on pmft_pkg.
module pmft_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  pmft_pkg::dp_stat_t stat,
  output logic               ready,
  output pmft_pkg::dp_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_MAPRD, S_OLDCHK, S_INVA, S_INVB,
    S_FINIT, S_FRD, S_FCHK, S_PROGH, S_PROGM,
    S_GCINIT, S_VSRD, S_VSCHK, S_MGINIT, S_MGRD, S_MGCHK, S_MGNEXT,
    S_ERINIT, S_ERSTEP, S_ERDONE,
    S_EMITRANGE, S_EMITR, S_EMITW, S_EMITF, S_EMITN
  } state_t;

  // Which search asked for a free page.
  typedef enum logic [1:0] {FC_FIRST, FC_SECOND, FC_MOVE} free_ctx_t;

  state_t    state, state_next;
  free_ctx_t fctx, fctx_next;
  logic      inv_move, inv_move_next;

  // Next state and command.
  always_comb begin
    state_next    = state;
    fctx_next     = fctx;
    inv_move_next = inv_move;
    cmd           = pmft_pkg::CMD_NOP;
    unique case (state)
      S_CLEAR: begin
        cmd = pmft_pkg::CMD_CLEAR;
        if (stat.clr_end) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd        = pmft_pkg::CMD_LATCH;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd        = pmft_pkg::CMD_MAP_RD;
        state_next = stat.range_bad ? S_EMITRANGE : S_MAPRD;
      end
      S_MAPRD: begin
        if (stat.op_read) begin
          state_next = S_EMITR;
        end else begin
          cmd        = pmft_pkg::CMD_HOST_WR;
          fctx_next  = FC_FIRST;
          state_next = stat.map_hit ? S_OLDCHK : S_FINIT;
        end
      end
      S_OLDCHK: begin
        inv_move_next = 1'b0;
        state_next    = stat.inv_ok ? S_INVA : S_FINIT;
      end
      S_INVA: begin
        cmd        = pmft_pkg::CMD_INV_A;
        state_next = S_INVB;
      end
      S_INVB: begin
        cmd        = pmft_pkg::CMD_INV_B;
        state_next = inv_move ? S_EMITN : S_FINIT;
      end
      S_FINIT: begin
        cmd        = pmft_pkg::CMD_FREE_INIT;
        state_next = S_FRD;
      end
      S_FRD: begin
        cmd        = pmft_pkg::CMD_FREE_RD;
        state_next = S_FCHK;
      end
      S_FCHK: begin
        cmd = pmft_pkg::CMD_FREE_CHK;
        if (stat.free_hit) begin
          state_next = (fctx == FC_MOVE) ? S_PROGM : S_PROGH;
        end else if (stat.scan_end) begin
          unique case (fctx)
            FC_FIRST:  state_next = S_GCINIT;
            FC_SECOND: state_next = S_EMITF;
            default: begin
              // A move found no room: leave the victim block as it is.
              fctx_next  = FC_SECOND;
              state_next = S_FINIT;
            end
          endcase
        end else begin
          state_next = S_FRD;
        end
      end
      S_PROGH: begin
        cmd        = pmft_pkg::CMD_PROG_HOST;
        state_next = S_EMITW;
      end
      S_PROGM: begin
        cmd           = pmft_pkg::CMD_PROG_MOVE;
        inv_move_next = 1'b1;
        state_next    = S_INVA;
      end
      S_GCINIT: begin
        cmd        = pmft_pkg::CMD_GC_INIT;
        state_next = S_VSRD;
      end
      S_VSRD: begin
        cmd        = pmft_pkg::CMD_VS_RD;
        state_next = S_VSCHK;
      end
      S_VSCHK: begin
        cmd = pmft_pkg::CMD_VS_CHK;
        if (stat.vs_end) begin
          if (stat.found) begin
            state_next = S_MGINIT;
          end else begin
            fctx_next  = FC_SECOND;
            state_next = S_FINIT;
          end
        end else begin
          state_next = S_VSRD;
        end
      end
      S_MGINIT: begin
        cmd        = pmft_pkg::CMD_PG_INIT;
        state_next = S_MGRD;
      end
      S_MGRD: begin
        cmd        = pmft_pkg::CMD_MG_RD;
        state_next = S_MGCHK;
      end
      S_MGCHK: begin
        cmd = pmft_pkg::CMD_MG_CHK;
        if (stat.mg_move) begin
          fctx_next  = FC_MOVE;
          state_next = S_FINIT;
        end else begin
          state_next = S_MGNEXT;
        end
      end
      S_MGNEXT: begin
        cmd        = pmft_pkg::CMD_PG_NEXT;
        state_next = stat.pg_end ? S_ERINIT : S_MGRD;
      end
      S_ERINIT: begin
        cmd        = pmft_pkg::CMD_PG_INIT;
        state_next = S_ERSTEP;
      end
      S_ERSTEP: begin
        cmd = pmft_pkg::CMD_ER_STEP;
        if (stat.pg_end) state_next = S_ERDONE;
      end
      S_ERDONE: begin
        cmd        = pmft_pkg::CMD_ER_DONE;
        fctx_next  = FC_SECOND;
        state_next = S_FINIT;
      end
      S_EMITN: begin
        if (!stat.notice_ok) begin
          state_next = S_MGNEXT;
        end else if (!stat.out_busy) begin
          cmd        = pmft_pkg::CMD_EMIT_NOTICE;
          state_next = S_MGNEXT;
        end
      end
      S_EMITRANGE: begin
        if (!stat.out_busy) begin
          cmd        = pmft_pkg::CMD_EMIT_RANGE;
          state_next = S_IDLE;
        end
      end
      S_EMITR: begin
        if (!stat.out_busy) begin
          cmd        = pmft_pkg::CMD_EMIT_READ;
          state_next = S_IDLE;
        end
      end
      S_EMITW: begin
        if (!stat.out_busy) begin
          cmd        = pmft_pkg::CMD_EMIT_WRITE;
          state_next = S_IDLE;
        end
      end
      S_EMITF: begin
        if (!stat.out_busy) begin
          cmd        = pmft_pkg::CMD_EMIT_FAIL;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and context registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      fctx     <= FC_FIRST;
      inv_move <= 1'b0;
    end else begin
      state    <= state_next;
      fctx     <= fctx_next;
      inv_move <= inv_move_next;
    end
  end

  assign ready = state == S_IDLE;

endmodule

[hw/rtl/page_mapped_flash_translation_top.sv]
// Sequence: a request is latched and its map entry read; an out-of-range request or a read
// then gives its word, and the next word is taken once the result is emitted. A write first
// invalidates the old page if one is mapped, then searches for a free page from the cursor.
// A collection scans the blocks for a victim, checks each of its pages, moves each valid page
// with its own free search and a notice (up to the cap), and erases the block. One request at a time.
// Reset: a clearing pass over max(2**(log2 BLOCK_COUNT + log2 PAGES_IN_BLOCK),
// LOGICAL_COUNT) table indices (1024 by default) runs before the first word is taken.
module page_mapped_flash_translation_top #(
  parameter int PAGES_IN_BLOCK = pmft_pkg::PAGES_IN_BLOCK_DEF,
  parameter int BLOCK_COUNT    = pmft_pkg::BLOCK_COUNT_DEF,
  parameter int LOGICAL_COUNT  = pmft_pkg::LOGICAL_COUNT_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [15:0]  s_tdata,  // logical_page[15:0]
  input  logic         s_tuser,  // operation
  output logic         m_tvalid,
  input  logic         m_tready,
  // status[1:0], physical_page[11:2], moved_logical_page[20:12],
  // source_page[30:21], host_write_total[62:31], flash_write_total[94:63],
  // collection_total[126:95], zero pad[127]
  output logic [127:0] m_tdata,
  output logic         m_tuser,  // result_kind
  output logic         m_tlast
);

`include "page_mapped_flash_translation_top_macros.svh"

  pmft_pkg::dp_cmd_t  cmd;
  pmft_pkg::dp_stat_t stat;

  pmft_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .stat     (stat),
    .ready    (s_tready),
    .cmd      (cmd)
  );

  pmft_datapath #(
    .PAGES_IN_BLOCK (PAGES_IN_BLOCK),
    .BLOCK_COUNT    (BLOCK_COUNT),
    .LOGICAL_COUNT  (LOGICAL_COUNT)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .stat     (stat)
  );

  // Checks on the sequencing.
  `PMFT_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready)
  `PMFT_ASSERT_IMP(a_notice_not_last, clk, rst, m_tvalid, m_tuser != m_tlast)
  `PMFT_ASSERT_IMP(a_no_emit_when_full, clk, rst, (cmd == pmft_pkg::CMD_EMIT_NOTICE) || (cmd == pmft_pkg::CMD_EMIT_WRITE) || (cmd == pmft_pkg::CMD_EMIT_FAIL), !stat.out_busy)

endmodule
